// ----- rtl/core/sacl_pkg.sv -----
`default_nettype none

package sacl_pkg;

    // Fixed field widths at the ports
    localparam int ADDR_W    = 32;
    localparam int WAY_OUT_W = 4;
    localparam int CNT_W     = 32;

    // Default geometry
    localparam int DEF_WAYS       = 4;
    localparam int DEF_SETS       = 128;
    localparam int DEF_LINE_BYTES = 32;
    localparam int DEF_AGE_WIDTH  = 16;

endpackage

`default_nettype wire

// ----- rtl/core/sacl_ram.sv -----
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/set_assoc_cache_lru_lookup.sv -----
// Set-associative tag store with age-counter LRU replacement. Each input beat
// carries a byte address; the block splits it into line offset, set index and
// tag, looks the set up and returns one result beat: hit, the way that hit or
// was filled or replaced, whether a valid line was evicted, and the running
// hit and access counts. All ways of a set (valid bit, age, tag) live in one
// row of a single-port-read, single-port-write RAM with a registered read. An
// access is a read-modify-write of that row: the row is read in the accept
// cycle, then compared, updated and written back in the lookup state, and no
// new address is taken until that write-back is done. While the result
// register is still held by out_stall, the written-back step waits. After
// reset the block clears the RAM one set per cycle and holds in_stall high
// until that sweep is done.
`default_nettype none

module set_assoc_cache_lru_lookup
    import sacl_pkg::*;
#(
    parameter int WAYS       = DEF_WAYS,
    parameter int SETS       = DEF_SETS,
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int AGE_WIDTH  = DEF_AGE_WIDTH
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ADDR_W-1:0]    address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [WAY_OUT_W-1:0] way,
    output logic                 evicted,
    output logic [CNT_W-1:0]     hit_total,
    output logic [CNT_W-1:0]     access_total
);

    localparam int OFF_W    = $clog2(LINE_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TREE_N   = 1 << WAY_W;
    localparam int ENT_W    = 1 + AGE_WIDTH + TAG_W;
    localparam int ROW_W    = WAYS * ENT_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [SET_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [SET_W-1:0]     idx_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [CNT_W-1:0]     hit_count_reg, access_count_reg;
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [WAY_W-1:0]     out_way_reg;
    logic                 out_evicted_reg;

    logic [SET_W-1:0]     in_idx;
    logic [TAG_W-1:0]     in_tag;
    logic                 accept_in;
    logic                 out_free;
    logic                 commit;
    logic                 clearing;

    logic                 ram_we;
    logic [SET_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     row_next;

    logic [WAYS-1:0]      ent_valid;
    logic [AGE_WIDTH-1:0] ent_age [WAYS];
    logic [TAG_W-1:0]     ent_tag [WAYS];
    logic [WAYS-1:0]      hit_vec;
    logic                 lk_hit;
    logic                 lk_full;
    logic                 lk_aging;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     inv_way;
    logic [WAY_W-1:0]     victim;
    logic [WAY_W-1:0]     sel_way;
    logic [AGE_WIDTH-1:0] node_age [2*TREE_N];
    logic [WAY_W-1:0]     node_way [2*TREE_N];

    assign in_idx    = address[OFF_W +: SET_W] & SET_W'(SETS - 1);
    assign in_tag    = TAG_W'(address >> (OFF_W + SET_BITS));
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept_in = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_LOOK) && out_free;
    assign clearing  = (state_reg == ST_CLEAR);

    assign ram_we    = clearing || commit;
    assign ram_waddr = clearing ? clr_idx_reg : idx_reg;
    assign ram_wdata = clearing ? '0 : row_next;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_sacl_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept_in),
        .raddr (in_idx),
        .rdata (rd_row)
    );

    // Split the row into ways: {valid, age, tag}
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            ent_valid[w] = rd_row[w*ENT_W + ENT_W - 1];
            ent_age[w]   = rd_row[w*ENT_W + TAG_W +: AGE_WIDTH];
            ent_tag[w]   = rd_row[w*ENT_W +: TAG_W];
            hit_vec[w]   = ent_valid[w] && (ent_tag[w] == tag_reg);
        end
    end

    // Lowest hitting way and lowest invalid way
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!ent_valid[w])
            begin
                inv_way = WAY_W'(w);
            end
        end
    end

    assign lk_hit   = |hit_vec;
    assign lk_full  = &ent_valid;
    assign lk_aging = lk_hit || lk_full;

    // Oldest way by a compare tree; right side wins only when strictly older,
    // so ties go to the lower way and padding leaves never win.
    always_comb
    begin
        for (int i = 0; i < TREE_N; i++)
        begin
            node_age[TREE_N + i] = (i < WAYS) ? ent_age[i] : '0;
            node_way[TREE_N + i] = WAY_W'(i);
        end
        node_age[0] = '0;
        node_way[0] = '0;
        for (int n = TREE_N - 1; n >= 1; n--)
        begin
            if (node_age[2*n + 1] > node_age[2*n])
            begin
                node_age[n] = node_age[2*n + 1];
                node_way[n] = node_way[2*n + 1];
            end
            else
            begin
                node_age[n] = node_age[2*n];
                node_way[n] = node_way[2*n];
            end
        end
        victim = node_way[1];
    end

    assign sel_way = lk_hit ? hit_way : (lk_full ? victim : inv_way);

    // Build the written-back row
    always_comb
    begin
        row_next = rd_row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == sel_way)
            begin
                row_next[w*ENT_W + ENT_W - 1] = 1'b1;
                row_next[w*ENT_W +: TAG_W]    = tag_reg;
                if (lk_aging)
                begin
                    row_next[w*ENT_W + TAG_W +: AGE_WIDTH] = '0;
                end
            end
            else if (lk_aging && ent_valid[w] && (ent_age[w] != {AGE_WIDTH{1'b1}}))
            begin
                row_next[w*ENT_W + TAG_W +: AGE_WIDTH] = ent_age[w] + AGE_WIDTH'(1);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            hit_count_reg    <= '0;
            access_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (commit)
            begin
                access_count_reg <= access_count_reg + CNT_W'(1);
                if (lk_hit)
                begin
                    hit_count_reg <= hit_count_reg + CNT_W'(1);
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            idx_reg <= in_idx;
            tag_reg <= in_tag;
        end
        if (commit)
        begin
            out_hit_reg     <= lk_hit;
            out_way_reg     <= sel_way;
            out_evicted_reg <= !lk_hit && lk_full;
        end
    end

    // Counters change only when a new result is loaded, so they serve as payload
    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign way          = WAY_OUT_W'(out_way_reg);
    assign evicted      = out_evicted_reg;
    assign hit_total    = hit_count_reg;
    assign access_total = access_count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sacl_checker.sv -----
`default_nettype none

module sacl_checker
    import sacl_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic                 hit,
    input wire logic [WAY_OUT_W-1:0] way,
    input wire logic                 evicted,
    input wire logic [CNT_W-1:0]     hit_total,
    input wire logic [CNT_W-1:0]     access_total
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(way) && $stable(hit)
            && $stable(evicted))
        else $error("result beat changed while stalled");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("hit reported with eviction");

    // Advance the access count by exactly one per new result
    a_access_step: assert property (@(posedge clk) disable iff (!rst_n)
        access_total != $past(access_total)
            |-> access_total == $past(access_total) + CNT_W'(1) && out_valid)
        else $error("access count stepped wrongly");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        hit_total != $past(hit_total)
            |-> hit && hit_total == $past(hit_total) + CNT_W'(1)
                && access_total != $past(access_total))
        else $error("hit count changed without a hit");

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (.*);

`default_nettype wire
